// ----- hw/rtl/voq_wfq_pkg.sv -----
`timescale 1ns / 1ps
package voq_wfq_pkg;

  localparam int unsigned ID_W = 16;
  localparam int unsigned INC_W = 16;
  localparam int unsigned NUM_INC = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OCC_W = 7;
  localparam int unsigned MAX_SERV = 8;

  localparam logic [1:0] CLS_LOW = 2'd1;
  localparam logic [1:0] CLS_HIGH = 2'd2;
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [15:0] INC_RESET [NUM_INC] = '{
    16'd9216, 16'd4608, 16'd3072, 16'd2304, 16'd1843, 16'd1536, 16'd1316, 16'd1152
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ARR_RD,
    ST_ARR_OUT,
    ST_SCAN,
    ST_PICK,
    ST_EMIT
  } state_t;

endpackage

// ----- hw/rtl/voq_wfq_store.sv -----
`timescale 1ns / 1ps
module voq_wfq_store
  import voq_wfq_pkg::*;
#(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 42
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/voq_weighted_fair_queue_switch.sv -----
`timescale 1ns / 1ps
// Weighted fair queueing scheduler with one virtual output queue per input and output pair.
// Queue counts, heads and tails sit in one small memory and queued packets in a second one;
// each has one read and one write port with a registered read. After reset a clearing pass
// zeroes all 2**(2*clog2(PORTS)) queue entries (64 for eight ports) while in_stall is
// high. Items are taken one at a time. An arrival reads its queue state in ST_ARR_RD and
// gives one result in ST_ARR_OUT. A tick serves each of the min(PORTS,8) outputs in turn:
// the inputs are looked up one per cycle through a two-stage read of queue state and then
// packet store, and each output gives one result, which waits while it is stalled.
module voq_weighted_fair_queue_switch
  import voq_wfq_pkg::*;
#(
  parameter int unsigned PORTS = 8,
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned FINISH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [INC_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [2:0]             in_port,
  input  logic [2:0]             out_port,
  input  logic [1:0]             prio,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             port,
  output logic                   accepted,
  output logic [ID_W-1:0]        packet_id,
  output logic [23:0]            virtual_finish,
  output logic                   grant_valid,
  output logic [2:0]             grant_input,
  output logic [1:0]             grant_priority,
  output logic                   output_drop,
  output logic                   departed,
  output logic [OCC_W-1:0]       occupancy,
  output logic                   last
);

  localparam int unsigned PW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QIW = 2 * PW;
  localparam int unsigned AW = QIW + QW;
  localparam int unsigned DW = ID_W + FINISH_BITS + 2;
  localparam int unsigned QSW = CW + 2 * QW;
  localparam int unsigned NSERV = (PORTS < MAX_SERV) ? PORTS : MAX_SERV;
  localparam int unsigned SW = (NSERV > 1) ? $clog2(NSERV) : 1;
  localparam int unsigned SCW = $clog2(NSERV + 1);
  localparam logic [FINISH_BITS-1:0] FIN_MAX = '1;

  state_t state, state_next;

  logic [INC_W-1:0] incr [NUM_INC];
  logic [FINISH_BITS-1:0] lf_low [PORTS];
  logic [FINISH_BITS-1:0] lf_high [PORTS];
  logic [FINISH_BITS-1:0] virtual_now;
  logic [CW-1:0] out_count [PORTS];
  logic [1:0] tick_phase;
  logic [ID_W-1:0] next_id;
  logic [PORTS-1:0] granted;
  logic [QIW-1:0] clr_idx;

  logic [2:0] r_in, r_out;
  logic [1:0] r_cls;
  logic [SW-1:0] srv;
  logic [SCW-1:0] scan;
  logic scan_vld;
  logic [SW-1:0] scan_j;
  logic hd_vld;
  logic [SW-1:0] hd_j;
  logic [QSW-1:0] hd_qe;
  logic best_vld;
  logic [SW-1:0] best_j;
  logic [QSW-1:0] best_qe;
  logic [FINISH_BITS-1:0] best_vf;
  logic [1:0] best_cls;
  logic [ID_W-1:0] best_id;

  logic st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [DW-1:0] st_wdata, st_rdata;

  logic q_we;
  logic [QIW-1:0] q_waddr, q_raddr;
  logic [QSW-1:0] q_wdata, q_rdata;
  logic [CW-1:0] q_cnt, best_cnt;
  logic [QW-1:0] q_hd, q_tl, best_hd, best_tl, tl_next, hd_next;

  logic [QIW-1:0] arr_q;
  logic arr_inrange;
  logic [FINISH_BITS-1:0] arr_lf, arr_start;
  logic [FINISH_BITS:0] arr_sum;
  logic [FINISH_BITS-1:0] arr_vf;
  logic arr_acc;
  logic [QIW-1:0] scan_q, best_q;
  logic [PW-1:0] srv_p, scan_p;
  logic [FINISH_BITS-1:0] rd_vf;
  logic [1:0] rd_cls;
  logic [ID_W-1:0] rd_id;
  logic take;
  logic drop_c, dep_c;
  logic [CW-1:0] occ_c;
  logic obuf_free, emit;

  assign srv_p = PW'(srv);
  assign scan_p = PW'(scan);
  assign arr_q = {PW'(r_in), PW'(r_out)};
  assign arr_inrange = (32'(r_in) < PORTS) && (32'(r_out) < PORTS);
  assign arr_lf = (r_cls == CLS_HIGH) ? lf_high[PW'(r_in)] : lf_low[PW'(r_in)];
  assign arr_start = (arr_lf > virtual_now) ? arr_lf : virtual_now;
  assign arr_sum = {1'b0, arr_start} + (FINISH_BITS+1)'(incr[r_in]);
  assign arr_vf = arr_sum[FINISH_BITS] ? FIN_MAX : arr_sum[FINISH_BITS-1:0];
  assign {q_cnt, q_hd, q_tl} = q_rdata;
  assign {best_cnt, best_hd, best_tl} = best_qe;
  assign tl_next = (32'(q_tl) == QUEUE_DEPTH - 1) ? '0 : q_tl + QW'(1);
  assign hd_next = (32'(best_hd) == QUEUE_DEPTH - 1) ? '0 : best_hd + QW'(1);
  assign arr_acc = arr_inrange && (32'(q_cnt) < QUEUE_DEPTH);
  assign scan_q = {scan_p, srv_p};
  assign best_q = {PW'(best_j), srv_p};
  assign {rd_id, rd_vf, rd_cls} = st_rdata;
  assign take = !best_vld || (rd_vf < best_vf) || (rd_cls > best_cls);
  assign drop_c = best_vld && !(32'(out_count[srv_p]) < QUEUE_DEPTH);
  assign occ_c = (best_vld && !drop_c) ? out_count[srv_p] + CW'(1) : out_count[srv_p];
  assign dep_c = (tick_phase == 2'd1) && (occ_c != '0);
  assign obuf_free = !out_valid || !out_stall;
  assign emit = (state == ST_ARR_OUT || state == ST_EMIT) && obuf_free;

  always_comb begin
    st_raddr = {PW'(scan_j), srv_p, q_hd};
    st_we = (state == ST_ARR_OUT) && obuf_free && arr_acc;
    st_waddr = {arr_q, q_tl};
    st_wdata = {next_id, arr_vf, r_cls};
  end

  always_comb begin
    q_raddr = (state == ST_SCAN) ? scan_q : arr_q;
    q_we = 1'b0;
    q_waddr = arr_q;
    q_wdata = {q_cnt + CW'(1), q_hd, tl_next};
    if (state == ST_CLEAR) begin
      q_we = 1'b1;
      q_waddr = clr_idx;
      q_wdata = '0;
    end else if (state == ST_ARR_OUT) begin
      q_we = obuf_free && arr_acc;
    end else if (state == ST_EMIT) begin
      q_we = obuf_free && best_vld;
      q_waddr = best_q;
      q_wdata = {best_cnt - CW'(1), hd_next, best_tl};
    end
  end

  voq_wfq_store #(.ADDR_W(AW), .DATA_W(DW)) u_store (
    .clk(clk), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
    .rd_addr(st_raddr), .rd_data(st_rdata)
  );

  voq_wfq_store #(.ADDR_W(QIW), .DATA_W(QSW)) u_qstate (
    .clk(clk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
    .rd_addr(q_raddr), .rd_data(q_rdata)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_next = (func == FUNC_TICK) ? ST_SCAN : ST_ARR_RD;
      end
      ST_ARR_RD: state_next = ST_ARR_OUT;
      ST_ARR_OUT: if (obuf_free) state_next = ST_IDLE;
      ST_SCAN: if (32'(scan) == NSERV) state_next = ST_PICK;
      ST_PICK: state_next = ST_EMIT;
      ST_EMIT: begin
        if (obuf_free) state_next = (32'(srv) == NSERV - 1) ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      for (int i = 0; i < NUM_INC; i++) incr[i] <= INC_RESET[i];
      for (int i = 0; i < PORTS; i++) begin
        lf_low[i] <= '0;
        lf_high[i] <= '0;
        out_count[i] <= '0;
      end
      virtual_now <= '0;
      tick_phase <= '0;
      next_id <= '0;
      out_valid <= 1'b0;
      granted <= '0;
      srv <= '0;
      scan <= '0;
      scan_vld <= 1'b0;
      hd_vld <= 1'b0;
      best_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) incr[cfg_index] <= cfg_data;
      if (out_valid && !out_stall && !emit) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: clr_idx <= clr_idx + QIW'(1);
        ST_IDLE: begin
          if (in_valid) begin
            r_in <= in_port;
            r_out <= out_port;
            r_cls <= (prio == CLS_HIGH) ? CLS_HIGH : CLS_LOW;
            granted <= '0;
            srv <= '0;
            scan <= '0;
            scan_vld <= 1'b0;
            hd_vld <= 1'b0;
            best_vld <= 1'b0;
          end
        end
        ST_ARR_RD: ;
        ST_ARR_OUT: begin
          if (obuf_free) begin
            out_valid <= 1'b1;
            port <= r_in;
            accepted <= arr_acc;
            packet_id <= next_id;
            virtual_finish <= arr_inrange ? 24'(arr_vf) : '0;
            grant_valid <= 1'b0;
            grant_input <= '0;
            grant_priority <= '0;
            output_drop <= 1'b0;
            departed <= 1'b0;
            occupancy <= '0;
            last <= 1'b1;
            next_id <= next_id + ID_W'(1);
            if (arr_inrange) begin
              if (r_cls == CLS_HIGH) lf_high[PW'(r_in)] <= arr_vf;
              else lf_low[PW'(r_in)] <= arr_vf;
            end
          end
        end
        ST_SCAN: begin
          // Queue state is read first, then the head packet of a nonempty queue.
          scan_vld <= (32'(scan) < NSERV);
          scan_j <= SW'(scan);
          if (32'(scan) < NSERV) scan <= scan + SCW'(1);
          hd_vld <= scan_vld && !granted[PW'(scan_j)] && (q_cnt != '0);
          hd_j <= scan_j;
          hd_qe <= q_rdata;
          if (hd_vld && take) begin
            best_vld <= 1'b1;
            best_j <= hd_j;
            best_qe <= hd_qe;
            best_vf <= rd_vf;
            best_cls <= rd_cls;
            best_id <= rd_id;
          end
        end
        ST_PICK: begin
          scan_vld <= 1'b0;
          hd_vld <= 1'b0;
          if (hd_vld && take) begin
            best_vld <= 1'b1;
            best_j <= hd_j;
            best_qe <= hd_qe;
            best_vf <= rd_vf;
            best_cls <= rd_cls;
            best_id <= rd_id;
          end
        end
        ST_EMIT: begin
          if (obuf_free) begin
            out_valid <= 1'b1;
            port <= 3'(srv);
            accepted <= 1'b0;
            packet_id <= best_vld ? best_id : '0;
            virtual_finish <= best_vld ? 24'(best_vf) : '0;
            grant_valid <= best_vld;
            grant_input <= best_vld ? 3'(best_j) : '0;
            grant_priority <= best_vld ? best_cls : '0;
            output_drop <= drop_c;
            departed <= dep_c;
            occupancy <= OCC_W'(occ_c);
            last <= (32'(srv) == NSERV - 1);
            out_count[srv_p] <= dep_c ? occ_c - CW'(1) : occ_c;
            if (best_vld) begin
              granted[PW'(best_j)] <= 1'b1;
              if (!drop_c && best_vf > virtual_now) virtual_now <= best_vf;
            end
            srv <= srv + SW'(1);
            scan <= '0;
            scan_vld <= 1'b0;
            hd_vld <= 1'b0;
            best_vld <= 1'b0;
            if (32'(srv) == NSERV - 1) tick_phase <= tick_phase + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && obuf_free) |=> out_valid)
    else $error("tick result not presented");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result lost");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable({port, packet_id, virtual_finish, last}))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("item taken while busy");

endmodule

// ----- sim/voq_weighted_fair_queue_switch_test.sv -----
`timescale 1ns / 1ps
module voq_weighted_fair_queue_switch_test
  import voq_wfq_pkg::*;
();

  localparam int NP = 8;
  localparam int QD = 64;
  localparam logic [23:0] FIN_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0] port;
    logic accepted;
    logic [15:0] packet_id;
    logic [23:0] virtual_finish;
    logic grant_valid;
    logic [2:0] grant_input;
    logic [1:0] grant_priority;
    logic output_drop;
    logic departed;
    logic [6:0] occupancy;
    logic last;
  } sched_result_t;

  typedef struct packed {
    logic [15:0] id;
    logic [23:0] vf;
    logic [1:0] cls;
  } queued_pkt_t;

  class wfq_scoreboard;
    queued_pkt_t voq[NP*NP][$];
    logic [23:0] fin_low[NP];
    logic [23:0] fin_high[NP];
    logic [23:0] vnow;
    int occ[NP];
    logic [1:0] phase;
    logic [15:0] seq_id;
    logic [15:0] incr[NP];
    sched_result_t pending[$];
    int errors;
    int arrivals;
    int ticks;
    int grants;
    int drops;

    function new();
      for (int i = 0; i < NP; i++) begin
        fin_low[i] = 0;
        fin_high[i] = 0;
        occ[i] = 0;
        incr[i] = INC_RESET[i];
      end
      vnow = 0;
      phase = 0;
      seq_id = 0;
      errors = 0;
      arrivals = 0;
      ticks = 0;
      grants = 0;
      drops = 0;
    endfunction

    function void note_item(logic f, logic [2:0] ip, logic [2:0] op, logic [1:0] pr);
      sched_result_t r;
      logic [1:0] cls;
      logic [23:0] start;
      logic [24:0] sum;
      bit taken[NP];
      bit dep_now;
      int best;
      queued_pkt_t bp;
      queued_pkt_t h;
      if (f == FUNC_ARRIVE) begin
        arrivals++;
        cls = (pr == CLS_HIGH) ? CLS_HIGH : CLS_LOW;
        r = '0;
        r.port = ip;
        r.packet_id = seq_id;
        r.last = 1;
        seq_id++;
        start = (cls == CLS_HIGH) ? fin_high[ip] : fin_low[ip];
        if (vnow > start) start = vnow;
        sum = start + incr[ip];
        r.virtual_finish = (sum > FIN_MAX) ? FIN_MAX : sum[23:0];
        if (cls == CLS_HIGH) fin_high[ip] = r.virtual_finish;
        else fin_low[ip] = r.virtual_finish;
        if (voq[ip*NP+op].size() < QD) begin
          voq[ip*NP+op].push_back({r.packet_id, r.virtual_finish, cls});
          r.accepted = 1;
        end
        pending.push_back(r);
      end else begin
        ticks++;
        dep_now = (phase == 1);
        for (int j = 0; j < NP; j++) taken[j] = 0;
        for (int o = 0; o < NP; o++) begin
          best = -1;
          bp = '0;
          for (int j = 0; j < NP; j++) begin
            if (!taken[j] && voq[j*NP+o].size() > 0) begin
              h = voq[j*NP+o][0];
              if (best < 0 || h.vf < bp.vf || h.cls > bp.cls) begin
                best = j;
                bp = h;
              end
            end
          end
          r = '0;
          r.port = 3'(o);
          if (best >= 0) begin
            grants++;
            taken[best] = 1;
            void'(voq[best*NP+o].pop_front());
            r.grant_valid = 1;
            r.grant_input = 3'(best);
            r.grant_priority = bp.cls;
            r.packet_id = bp.id;
            r.virtual_finish = bp.vf;
            if (occ[o] < QD) begin
              occ[o]++;
              if (bp.vf > vnow) vnow = bp.vf;
            end else begin
              r.output_drop = 1;
              drops++;
            end
          end
          r.occupancy = 7'(occ[o]);
          if (dep_now && occ[o] > 0) begin
            occ[o]--;
            r.departed = 1;
          end
          r.last = (o == NP - 1);
          pending.push_back(r);
        end
        phase++;
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [INC_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic func;
  logic [2:0] in_port, out_port;
  logic [1:0] prio;
  logic out_valid, out_stall;
  sched_result_t res;
  wfq_scoreboard sb;
  int cycles;
  bit rx_pause;

  voq_weighted_fair_queue_switch DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .in_port(in_port),
    .out_port(out_port), .prio(prio), .out_valid(out_valid), .out_stall(out_stall),
    .port(res.port), .accepted(res.accepted), .packet_id(res.packet_id),
    .virtual_finish(res.virtual_finish), .grant_valid(res.grant_valid),
    .grant_input(res.grant_input), .grant_priority(res.grant_priority),
    .output_drop(res.output_drop), .departed(res.departed), .occupancy(res.occupancy),
    .last(res.last)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) sb.check_result(res);
    if (cycles > 400000) begin
      $display("voq_weighted_fair_queue_switch_test: errors");
      $finish;
    end
  end

  initial begin
    int w;
    out_stall = 1;
    @(negedge rst);
    forever begin
      w = rx_pause ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) w = 0;
      out_stall <= (w != 0);
      repeat (w) @(posedge clk);
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_incr(int idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.incr[idx] = val;
    @(posedge clk);
  endtask

  task automatic send_item(logic f, logic [2:0] ip, logic [2:0] op, logic [1:0] pr,
                           bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 11) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    in_port <= ip;
    out_port <= op;
    prio <= pr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(f, ip, op, pr);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_phase(int n, int hot_out);
    logic [2:0] op;
    bit gaps;
    for (int k = 0; k < n; k++) begin
      gaps = (k % 40) >= 10;
      op = (hot_out >= 0 && $urandom_range(0, 1)) ? 3'(hot_out) : 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) send_item(FUNC_TICK, 0, 0, 0, gaps);
      else send_item(FUNC_ARRIVE, 3'($urandom_range(0, 7)), op, 2'($urandom_range(0, 3)),
                     gaps);
    end
  endtask

  initial begin
    cycles = 0;
    rx_pause = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    func = 0;
    in_port = 0;
    out_port = 0;
    prio = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_item(FUNC_TICK, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) begin
      send_item(FUNC_ARRIVE, 3'(i), 3'(7 - i), (i % 2) ? CLS_HIGH : CLS_LOW, 0);
    end
    send_item(FUNC_ARRIVE, 3, 3, 2'd0, 0);
    send_item(FUNC_ARRIVE, 5, 3, 2'd3, 0);
    send_item(FUNC_ARRIVE, 7, 0, CLS_HIGH, 0);
    send_item(FUNC_ARRIVE, 0, 0, CLS_LOW, 0);
    for (int i = 0; i < 6; i++) send_item(FUNC_TICK, 0, 0, 0, 0);
    drain();

    write_incr(0, 16'hFFFF);
    write_incr(1, 16'h0000);
    for (int i = 2; i < 8; i++) write_incr(i, 16'($urandom_range(0, 65535)));
    for (int i = 0; i < 66; i++) send_item(FUNC_ARRIVE, 0, 1, CLS_HIGH, 0);
    for (int i = 0; i < 6; i++) send_item(FUNC_ARRIVE, 1, 2, CLS_LOW, 0);
    send_item(FUNC_ARRIVE, 0, 2, CLS_LOW, 0);
    random_phase(30, 2);
    drain();

    for (int i = 0; i < 8; i++) write_incr(i, 16'($urandom_range(1, 4000)));
    random_phase(30, -1);
    drain();

    for (int i = 0; i < 8; i++) write_incr(i, (i % 2) ? 16'hFFFF : 16'h0001);
    random_phase(28, 4);
    rx_pause = 1;
    drain();

    $display("Covered %0d arrivals and %0d ticks with %0d grants and %0d output drops.",
             sb.arrivals, sb.ticks, sb.grants, sb.drops);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("voq_weighted_fair_queue_switch_test: clean");
    end else begin
      $display("voq_weighted_fair_queue_switch_test: errors");
    end
    $finish;
  end
endmodule
